// ===== hdl/range_median_filter_defines.svh =====
// Assertion macros for the range median filter.
`ifndef RANGE_MEDIAN_FILTER_DEFINES_SVH
`define RANGE_MEDIAN_FILTER_DEFINES_SVH
`ifndef SYNTH
// Check a consequence in the same cycle as its cause.
`define RMF_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("range median filter check failed");
// Check a consequence in the cycle after its cause.
`define RMF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("range median filter check failed");
`else
`define RMF_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define RMF_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/rmf_pkg.sv =====
// Shared types, widths and register codes of the range median filter.
`default_nettype none
package rmf_pkg;

    // field widths
    localparam int unsigned DIST_W  = 16;
    localparam int unsigned TILT_W  = 16;
    localparam int unsigned DIV_W   = 24;
    localparam int unsigned OFF_W   = 11;
    localparam int unsigned WLEN_W  = 5;
    localparam int unsigned RANK_W  = 4;
    localparam int unsigned GAIN_W  = 9;
    localparam int unsigned DECAY_W = 16;

    // configuration port
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_OFFSET       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MEDIAN_RANK        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTRAPOLATION_GAIN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MAX          = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DIVERGENCE_DECAY   = 3'd5;

    // register reset values
    localparam logic [OFF_W-1:0]   RST_RANGE_OFFSET  = 11'd0;
    localparam logic [WLEN_W-1:0]  RST_WINDOW_LENGTH = 5'd9;
    localparam logic [RANK_W-1:0]  RST_MEDIAN_RANK   = 4'd5;
    localparam logic [GAIN_W-1:0]  RST_GAIN          = 9'd0;
    localparam logic [DIST_W-1:0]  RST_RANGE_MAX     = 16'd4000;
    localparam logic [DECAY_W-1:0] RST_DECAY         = 16'd58982;

    // history storage
    localparam int unsigned DEF_HISTORY_DEPTH = 16;

    // shared multiplier operand widths (signed)
    localparam int unsigned MUL_A_W = 25;
    localparam int unsigned MUL_B_W = 17;
    localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MULS,
        ST_SAMP,
        ST_CLOAD,
        ST_SCAN,
        ST_CHECK,
        ST_MULG,
        ST_FRESH,
        ST_MULD,
        ST_DIV,
        ST_DONE
    } t_state;

endpackage
`default_nettype wire

// ===== hdl/rmf_in_if.sv =====
// Input channel of the range median filter: one range sample word.
`default_nettype none
interface rmf_in_if;
    import rmf_pkg::*;

    logic              valid;
    logic              ready;
    logic [DIST_W-1:0] raw_distance;
    logic              read_failed;
    logic [TILT_W-1:0] tilt_factor;

    modport source (output valid, raw_distance, read_failed, tilt_factor, input ready);
    modport sink   (input valid, raw_distance, read_failed, tilt_factor, output ready);
endinterface
`default_nettype wire

// ===== hdl/rmf_out_if.sv =====
// Output channel of the range median filter: one filtered result word.
`default_nettype none
interface rmf_out_if;
    import rmf_pkg::*;

    logic              valid;
    logic              ready;
    logic [DIST_W-1:0] filtered_distance;
    logic [DIST_W-1:0] previous_distance;
    logic [DIV_W-1:0]  divergence;
    logic              sample_rejected;

    modport source (output valid, filtered_distance, previous_distance, divergence,
                    sample_rejected, input ready);
    modport sink   (input valid, filtered_distance, previous_distance, divergence,
                    sample_rejected, output ready);
endinterface
`default_nettype wire

// ===== hdl/range_median_filter.sv =====
// Top level of the range median filter: sequencer, history memory and shared multiplier.
//
// Usage: samples arrive as words on i_in (valid/ready), results leave as words on
// o_out (valid/ready), one result word for each sample word. Registers are written
// through i_cfg_we / i_cfg_idx / i_cfg_data while no sample is in flight.
// The block takes one sample at a time; i_in.ready is high only while it waits.
// A failed read goes from acceptance straight to the done state, then to the output register.
// A good read runs through the shared multiplier three times and selects the
// configured rank by a rank count: each candidate entry is compared against all n
// window entries, one compare a cycle from the history memory's read port; the
// selection stops at the candidate of the wanted rank, after k candidates (1 <= k <= n).
// Each candidate passes the load, scan and check states; the default window is 9.
// A finished result waits in the output register while the receiver stalls; a new
// sample may already be accepted and runs up to its last step, then holds.
// Reset (i_rst_n low, synchronous) restores the register defaults, clears the
// history through per-entry valid bits at once, and drops any pending result.
`default_nettype none
`include "range_median_filter_defines.svh"
module range_median_filter #(
    parameter int unsigned HISTORY_DEPTH = rmf_pkg::DEF_HISTORY_DEPTH
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    rmf_in_if.sink                              i_in,
    rmf_out_if.source                           o_out,
    input  wire logic                           i_cfg_we,
    input  wire logic [rmf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [rmf_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import rmf_pkg::*;

    localparam int unsigned IW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int unsigned LW = $clog2(HISTORY_DEPTH + 1);
    localparam logic [7:0]  DEPTH_B = 8'(HISTORY_DEPTH);

    // configuration registers
    logic [OFF_W-1:0]   r_off;
    logic [WLEN_W-1:0]  r_wlen;
    logic [RANK_W-1:0]  r_rank_cfg;
    logic [GAIN_W-1:0]  r_gain;
    logic [DIST_W-1:0]  r_rmax;
    logic [DECAY_W-1:0] r_decay;

    // filter state
    logic [IW-1:0]      r_wp,   n_wp;
    logic [DIST_W-1:0]  r_cur,  n_cur;
    logic [DIST_W-1:0]  r_last, n_last;
    logic [DIV_W-1:0]   r_div,  n_div;

    // sequencer and work registers
    t_state             r_state, n_state;
    logic [DIST_W-1:0]  r_raw,  n_raw;
    logic [TILT_W-1:0]  r_tilt, n_tilt;
    logic               r_fail, n_fail;
    logic [LW-1:0]      r_len,  n_len;
    logic [LW-1:0]      r_rank, n_rank;
    logic [IW-1:0]      r_i,    n_i;
    logic [LW-1:0]      r_j,    n_j;
    logic [IW-1:0]      r_jd,   n_jd;
    logic               r_cmp_vld, n_cmp_vld;
    logic [LW-1:0]      r_cnt,  n_cnt;
    logic [DIST_W-1:0]  r_cand, n_cand;
    logic [DIST_W-1:0]  r_med,  n_med;
    logic [DIST_W-1:0]  r_dev,  n_dev;
    logic [MUL_P_W-1:0] r_prod;

    // output register
    logic               r_o_vld, n_o_vld;
    logic [DIST_W-1:0]  r_o_filt;
    logic [DIST_W-1:0]  r_o_prev;
    logic [DIV_W-1:0]   r_o_div;
    logic               r_o_rej;

    // history memory with per-entry valid bits
    logic [DIST_W-1:0]  r_mem [HISTORY_DEPTH];
    logic [HISTORY_DEPTH-1:0] r_mem_vld;
    logic [DIST_W-1:0]  r_rd;
    logic               r_rd_vld;
    logic [IW-1:0]      rd_addr;
    logic               mem_we;
    logic [IW-1:0]      wr_addr;
    logic [DIST_W-1:0]  wr_data;
    logic [DIST_W-1:0]  rd_data;

    // multiplier operands
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;

    // handshake
    logic in_acc;
    logic out_free;
    logic load_out;

    // window length and rank as seen by a new sample
    logic [7:0]    wlen_b;
    logic [7:0]    len_b;
    logic [7:0]    rank_b;
    logic [LW-1:0] len_eff;
    logic [LW-1:0] rank_eff;

    assign in_acc   = i_in.valid && i_in.ready;
    assign out_free = !r_o_vld || o_out.ready;
    assign load_out = (r_state == ST_DONE) && out_free;
    assign rd_data  = r_rd_vld ? r_rd : '0;

    always_comb begin
        wlen_b = {3'b0, r_wlen};
        if (wlen_b == 8'd0) begin
            len_b = 8'd1;
        end else if (wlen_b > DEPTH_B) begin
            len_b = DEPTH_B;
        end else begin
            len_b = wlen_b;
        end
        rank_b   = {4'b0, r_rank_cfg};
        len_eff  = LW'(len_b);
        rank_eff = (rank_b >= len_b) ? LW'(len_b - 8'd1) : LW'(rank_b);
    end

    // write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off      <= RST_RANGE_OFFSET;
            r_wlen     <= RST_WINDOW_LENGTH;
            r_rank_cfg <= RST_MEDIAN_RANK;
            r_gain     <= RST_GAIN;
            r_rmax     <= RST_RANGE_MAX;
            r_decay    <= RST_DECAY;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_RANGE_OFFSET:       r_off      <= i_cfg_data[OFF_W-1:0];
                CFG_WINDOW_LENGTH:      r_wlen     <= i_cfg_data[WLEN_W-1:0];
                CFG_MEDIAN_RANK:        r_rank_cfg <= i_cfg_data[RANK_W-1:0];
                CFG_EXTRAPOLATION_GAIN: r_gain     <= i_cfg_data[GAIN_W-1:0];
                CFG_RANGE_MAX:          r_rmax     <= i_cfg_data[DIST_W-1:0];
                CFG_DIVERGENCE_DECAY:   r_decay    <= i_cfg_data[DECAY_W-1:0];
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = i_in.read_failed ? ST_DONE : ST_MULS;
                end
            end
            ST_MULS:  n_state = ST_SAMP;
            ST_SAMP:  n_state = ST_CLOAD;
            ST_CLOAD: n_state = ST_SCAN;
            ST_SCAN: begin
                if (r_j == r_len) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: n_state = (r_cnt == r_rank) ? ST_MULG : ST_CLOAD;
            ST_MULG:  n_state = ST_FRESH;
            ST_FRESH: n_state = ST_MULD;
            ST_MULD:  n_state = ST_DIV;
            ST_DIV:   n_state = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs: ready, memory address, multiplier operands
    always_comb begin
        i_in.ready = (r_state == ST_IDLE);
        rd_addr    = (r_state == ST_CLOAD) ? r_i : r_j[IW-1:0];
        mul_a      = '0;
        mul_b      = '0;
        case (r_state)
            ST_MULS: begin
                mul_a = $signed({{(MUL_A_W-DIST_W){1'b0}}, r_raw});
                mul_b = $signed({{(MUL_B_W-TILT_W){1'b0}}, r_tilt});
            end
            ST_MULG: begin
                mul_a = MUL_A_W'($signed({1'b0, r_med}) - $signed({1'b0, r_cur}));
                mul_b = $signed({{(MUL_B_W-GAIN_W){1'b0}}, r_gain});
            end
            ST_MULD: begin
                mul_a = $signed({{(MUL_A_W-DIV_W){1'b0}}, r_div});
                mul_b = $signed({{(MUL_B_W-DECAY_W){1'b0}}, r_decay});
            end
            default: ;
        endcase
    end

    // datapath next values
    always_comb begin
        logic [DIST_W:0]   scaled;
        logic [DIST_W:0]   sample;
        logic [IW-1:0]     wp_eff;
        logic [LW-1:0]     wp_inc;
        logic              less;
        logic [DIST_W:0]   med_sum;
        logic signed [28:0] t;
        logic [19:0]       q;
        logic [DIST_W-1:0] fresh;
        logic [DIV_W:0]    d;

        n_raw     = r_raw;
        n_tilt    = r_tilt;
        n_fail    = r_fail;
        n_len     = r_len;
        n_rank    = r_rank;
        n_wp      = r_wp;
        n_cur     = r_cur;
        n_last    = r_last;
        n_div     = r_div;
        n_i       = r_i;
        n_j       = r_j;
        n_jd      = r_jd;
        n_cmp_vld = r_cmp_vld;
        n_cnt     = r_cnt;
        n_cand    = r_cand;
        n_med     = r_med;
        n_dev     = r_dev;
        mem_we    = 1'b0;
        wr_addr   = '0;
        wr_data   = '0;

        scaled  = r_prod[DIST_W+15:15];
        sample  = '0;
        wp_eff  = (LW'(r_wp) >= LW'(HISTORY_DEPTH)) ? '0 : r_wp;
        wp_inc  = LW'(wp_eff) + LW'(1);
        less    = (rd_data < r_cand) || ((rd_data == r_cand) && (r_jd < r_i));
        med_sum = {1'b0, r_cand} + {1'b0, r_cur};
        t       = $signed({5'b0, r_med, 8'b0}) + $signed({r_prod[27], r_prod[27:0]});
        q       = t[27:8];
        fresh   = '0;
        d       = {1'b0, r_prod[DIV_W+15:16]} + {1'b0, r_dev, 8'b0};

        case (r_state)
            ST_IDLE: begin
                // latch the sample and the window setup
                if (in_acc) begin
                    n_raw  = i_in.raw_distance;
                    n_tilt = i_in.tilt_factor;
                    n_fail = i_in.read_failed;
                    n_len  = len_eff;
                    n_rank = rank_eff;
                end
            end
            ST_SAMP: begin
                // drop the offset, clamp, store and advance the ring position
                if (scaled > {6'b0, r_off}) begin
                    sample = scaled - {6'b0, r_off};
                end
                mem_we  = 1'b1;
                wr_addr = wp_eff;
                wr_data = sample[DIST_W] ? {DIST_W{1'b1}} : sample[DIST_W-1:0];
                n_wp    = (wp_inc >= r_len) ? '0 : wp_inc[IW-1:0];
                n_i     = '0;
            end
            ST_CLOAD: begin
                n_j       = '0;
                n_cmp_vld = 1'b0;
                n_cnt     = '0;
            end
            ST_SCAN: begin
                // take the candidate, then count entries that sort before it
                if (r_j == '0) begin
                    n_cand = rd_data;
                end
                if (r_cmp_vld && less) begin
                    n_cnt = r_cnt + LW'(1);
                end
                n_cmp_vld = (r_j < r_len);
                n_jd      = r_j[IW-1:0];
                if (r_j < r_len) begin
                    n_j = r_j + LW'(1);
                end
            end
            ST_CHECK: begin
                n_med = med_sum[DIST_W:1];
                n_i   = r_i + IW'(1);
            end
            ST_FRESH: begin
                // clamp the extrapolated distance and shift the history of outputs
                if (t[28]) begin
                    fresh = '0;
                end else if (q > {4'b0, r_rmax}) begin
                    fresh = r_rmax;
                end else begin
                    fresh = q[DIST_W-1:0];
                end
                n_last = r_cur;
                n_cur  = fresh;
                n_dev  = (r_med > fresh) ? (r_med - fresh) : (fresh - r_med);
            end
            ST_DIV: begin
                // leak and add the deviation, saturating
                n_div = d[DIV_W] ? {DIV_W{1'b1}} : d[DIV_W-1:0];
            end
            default: ;
        endcase
    end

    // output valid: set on load, drop on handshake
    always_comb begin
        n_o_vld = r_o_vld;
        if (load_out) begin
            n_o_vld = 1'b1;
        end else if (o_out.ready) begin
            n_o_vld = 1'b0;
        end
    end

    // control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_wp      <= '0;
            r_cur     <= '0;
            r_last    <= '0;
            r_div     <= '0;
            r_o_vld   <= 1'b0;
            r_cmp_vld <= 1'b0;
            r_i       <= '0;
            r_j       <= '0;
            r_cnt     <= '0;
            r_len     <= '0;
            r_rank    <= '0;
        end else begin
            r_state   <= n_state;
            r_wp      <= n_wp;
            r_cur     <= n_cur;
            r_last    <= n_last;
            r_div     <= n_div;
            r_o_vld   <= n_o_vld;
            r_cmp_vld <= n_cmp_vld;
            r_i       <= n_i;
            r_j       <= n_j;
            r_cnt     <= n_cnt;
            r_len     <= n_len;
            r_rank    <= n_rank;
        end
    end

    // payload registers and the shared multiplier
    always_ff @(posedge i_clk) begin
        r_raw  <= n_raw;
        r_tilt <= n_tilt;
        r_fail <= n_fail;
        r_jd   <= n_jd;
        r_cand <= n_cand;
        r_med  <= n_med;
        r_dev  <= n_dev;
        r_prod <= MUL_P_W'(mul_a * mul_b);
        if (load_out) begin
            r_o_filt <= r_cur;
            r_o_prev <= r_last;
            r_o_div  <= r_div;
            r_o_rej  <= r_fail;
        end
    end

    // history memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd <= r_mem[rd_addr];
    end

    // entry valid bits: cleared at reset, set on write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_vld <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            if (mem_we) begin
                r_mem_vld[wr_addr] <= 1'b1;
            end
            r_rd_vld <= r_mem_vld[rd_addr];
        end
    end

    assign o_out.valid             = r_o_vld;
    assign o_out.filtered_distance = r_o_filt;
    assign o_out.previous_distance = r_o_prev;
    assign o_out.divergence        = r_o_div;
    assign o_out.sample_rejected   = r_o_rej;

    // checks on the sequencer
    `RMF_ASSERT_NEXT(a_fail_skips, i_clk, i_rst_n, in_acc && i_in.read_failed, r_state == ST_DONE)
    `RMF_ASSERT_SAME(a_rank_in_window, i_clk, i_rst_n, r_state == ST_CHECK, r_cnt < r_len)
    `RMF_ASSERT_SAME(a_wp_in_window, i_clk, i_rst_n, r_state == ST_CLOAD, LW'(r_wp) < r_len)
    `RMF_ASSERT_SAME(a_scan_bound, i_clk, i_rst_n, r_state == ST_SCAN, r_j <= r_len)

endmodule
`default_nettype wire
